// ===== design/bms_pkg.sv =====
// Shared types, constants and control encodings for the bulk error marking selector.
package bms_pkg;

    // Fixed field widths.
    localparam int VALUE_W     = 32;
    localparam int FRAC_W      = 17;
    localparam int TOTAL_W     = 36;
    localparam int ELEM_IDX_W  = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Each list emits at most this many elements.
    localparam int LIST_CAP = 16;
    localparam int TAKEN_W  = 5;

    // Split of the fraction times total product into two half products.
    localparam int HALF_W  = 18;
    localparam int PROD_W  = FRAC_W + HALF_W;
    localparam int LIMIT_W = FRAC_W + TOTAL_W;

    // Fraction encodings.
    localparam logic [FRAC_W-1:0] FRAC_ONE   = 17'h10000;
    localparam logic [FRAC_W-1:0] FRAC_RESET = 17'd19661;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_REFINE_FRACTION  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REFINE_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COARSE_FRACTION  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COARSE_THRESHOLD = 2'd3;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_REFINE = 2'd0,
        KIND_COARSE = 2'd1,
        KIND_CLOSE  = 2'd2
    } list_kind_t;

    // Input transaction payload.
    typedef struct packed {
        logic [VALUE_W-1:0] error_value;
        logic               last;
    } bms_item_t;

    // Output transaction payload.
    typedef struct packed {
        logic [ELEM_IDX_W-1:0] element_index;
        list_kind_t            list_kind;
        logic                  overflow;
        logic                  end_of_run;
    } bms_result_t;

    // Read address selection relative to the walk pointer.
    typedef enum logic [1:0] {
        ADDR_PTR    = 2'd0,
        ADDR_PTR_M1 = 2'd1,
        ADDR_PTR_M2 = 2'd2
    } addr_mode_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WALK,
        ST_INS_PUT,
        ST_DECIDE,
        ST_ALL_REF,
        ST_ALL_COA,
        ST_REF_MUL_LO,
        ST_REF_MUL_HI,
        ST_REF_RD,
        ST_REF_CHK,
        ST_COA_MUL_LO,
        ST_COA_MUL_HI,
        ST_COA_RD,
        ST_COA_CHK,
        ST_CLOSE
    } bms_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;
        logic       ovf_set;
        logic       ptr_to_count;
        logic       ptr_clr;
        logic       ptr_dec;
        logic       ptr_inc;
        logic       rd_en;
        addr_mode_t addr_mode;
        logic       wr_shift;
        logic       wr_new;
        logic       commit;
        logic       coarse;
        logic       mul_lo;
        logic       mul_hi;
        logic       scan_init;
        logic       take;
        logic       emit_seq;
        logic       emit_close;
        logic       clear_run;
    } bms_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic room;
        logic count_zero;
        logic item_last;
        logic ptr_zero;
        logic ptr_one;
        logic ptr_at_count;
        logic taken_full;
        logic rd_gt_v;
        logic ref_all;
        logic coa_all;
        logic ref_ok;
        logic coa_ok;
        logic out_free;
    } bms_stat_t;

endpackage

// ===== design/bms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bms_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/bms_controller.sv =====
// Sequencer that steps the datapath through insertion, list scans and the closing item.
module bms_controller
    import bms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  bms_stat_t stat,
    output bms_cmd_t  cmd
);

    bms_state_t state_reg;
    bms_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (!stat.room)
                    begin
                        state_next = ST_DECIDE;
                    end
                    else if (stat.count_zero)
                    begin
                        state_next = ST_INS_PUT;
                    end
                    else
                    begin
                        state_next = ST_INS_RD;
                    end
                end
            end
            ST_INS_RD:
            begin
                state_next = ST_INS_WALK;
            end
            ST_INS_WALK:
            begin
                if (!stat.rd_gt_v || stat.ptr_one)
                begin
                    state_next = ST_INS_PUT;
                end
            end
            ST_INS_PUT:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!stat.item_last)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.ref_all)
                begin
                    state_next = ST_ALL_REF;
                end
                else if (stat.coa_all)
                begin
                    state_next = ST_ALL_COA;
                end
                else
                begin
                    state_next = ST_REF_MUL_LO;
                end
            end
            ST_ALL_REF, ST_ALL_COA:
            begin
                if (stat.ptr_at_count || stat.taken_full)
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_REF_MUL_LO:
            begin
                state_next = ST_REF_MUL_HI;
            end
            ST_REF_MUL_HI:
            begin
                state_next = ST_REF_RD;
            end
            ST_REF_RD:
            begin
                if (stat.ptr_zero || stat.taken_full)
                begin
                    state_next = ST_COA_MUL_LO;
                end
                else
                begin
                    state_next = ST_REF_CHK;
                end
            end
            ST_REF_CHK:
            begin
                if (!stat.ref_ok)
                begin
                    state_next = ST_COA_MUL_LO;
                end
                else if (stat.out_free)
                begin
                    state_next = ST_REF_RD;
                end
            end
            ST_COA_MUL_LO:
            begin
                state_next = ST_COA_MUL_HI;
            end
            ST_COA_MUL_HI:
            begin
                state_next = ST_COA_RD;
            end
            ST_COA_RD:
            begin
                if (stat.ptr_at_count || stat.taken_full)
                begin
                    state_next = ST_CLOSE;
                end
                else
                begin
                    state_next = ST_COA_CHK;
                end
            end
            ST_COA_CHK:
            begin
                if (!stat.coa_ok)
                begin
                    state_next = ST_CLOSE;
                end
                else if (stat.out_free)
                begin
                    state_next = ST_COA_RD;
                end
            end
            ST_CLOSE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath commands.
    always_comb
    begin
        cmd = '0;
        cmd.addr_mode = ADDR_PTR;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.room)
                    begin
                        cmd.ptr_to_count = 1'b1;
                    end
                    else
                    begin
                        cmd.ovf_set = 1'b1;
                    end
                end
            end
            ST_INS_RD:
            begin
                cmd.rd_en     = 1'b1;
                cmd.addr_mode = ADDR_PTR_M1;
            end
            ST_INS_WALK:
            begin
                // Larger entries move up one place; the next one down is read meanwhile.
                if (stat.rd_gt_v)
                begin
                    cmd.wr_shift = 1'b1;
                    cmd.ptr_dec  = 1'b1;
                    if (!stat.ptr_one)
                    begin
                        cmd.rd_en     = 1'b1;
                        cmd.addr_mode = ADDR_PTR_M2;
                    end
                end
            end
            ST_INS_PUT:
            begin
                cmd.wr_new = 1'b1;
                cmd.commit = 1'b1;
            end
            ST_DECIDE:
            begin
                if (stat.item_last)
                begin
                    cmd.scan_init = 1'b1;
                    cmd.ptr_clr   = 1'b1;
                end
            end
            ST_ALL_REF, ST_ALL_COA:
            begin
                cmd.coarse = (state_reg == ST_ALL_COA);
                if (!(stat.ptr_at_count || stat.taken_full) && stat.out_free)
                begin
                    cmd.emit_seq = 1'b1;
                    cmd.ptr_inc  = 1'b1;
                end
            end
            ST_REF_MUL_LO:
            begin
                cmd.mul_lo       = 1'b1;
                cmd.scan_init    = 1'b1;
                cmd.ptr_to_count = 1'b1;
            end
            ST_REF_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
            end
            ST_REF_RD:
            begin
                if (!(stat.ptr_zero || stat.taken_full))
                begin
                    cmd.rd_en     = 1'b1;
                    cmd.addr_mode = ADDR_PTR_M1;
                end
            end
            ST_REF_CHK:
            begin
                if (stat.ref_ok && stat.out_free)
                begin
                    cmd.take    = 1'b1;
                    cmd.ptr_dec = 1'b1;
                end
            end
            ST_COA_MUL_LO:
            begin
                cmd.coarse    = 1'b1;
                cmd.mul_lo    = 1'b1;
                cmd.scan_init = 1'b1;
                cmd.ptr_clr   = 1'b1;
            end
            ST_COA_MUL_HI:
            begin
                cmd.coarse = 1'b1;
                cmd.mul_hi = 1'b1;
            end
            ST_COA_RD:
            begin
                cmd.coarse = 1'b1;
                if (!(stat.ptr_at_count || stat.taken_full))
                begin
                    cmd.rd_en     = 1'b1;
                    cmd.addr_mode = ADDR_PTR;
                end
            end
            ST_COA_CHK:
            begin
                cmd.coarse = 1'b1;
                if (stat.coa_ok && stat.out_free)
                begin
                    cmd.take    = 1'b1;
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_CLOSE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_close = 1'b1;
                    cmd.clear_run  = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Items are taken only between runs of work.
    assign item_stall = (state_reg != ST_IDLE);

endmodule

// ===== design/bms_datapath.sv =====
// Storage, sorted order memory, bulk limit arithmetic and output register.
module bms_datapath
    import bms_pkg::*;
#(
    parameter int MAX_ELEMENTS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bms_item_t              item,
    input  logic                   cfg_write_enable,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  bms_cmd_t               cmd,
    output bms_stat_t              stat,
    input  logic                   result_stall,
    output logic                   result_valid,
    output bms_result_t            result
);

    localparam int IDXW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW      = $clog2(MAX_ELEMENTS + 1);
    localparam int ENTRY_W = VALUE_W + IDXW;

    // One sorted entry: value plus its load position.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [IDXW-1:0]    idx;
    } entry_t;

    logic [FRAC_W-1:0]  ref_frac_reg, ref_frac_next;
    logic [VALUE_W-1:0] ref_thr_reg, ref_thr_next;
    logic [FRAC_W-1:0]  coa_frac_reg, coa_frac_next;
    logic [VALUE_W-1:0] coa_thr_reg, coa_thr_next;

    logic [VALUE_W-1:0] v_reg, v_next;
    logic               last_reg, last_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               ovf_reg, ovf_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic [TAKEN_W-1:0] taken_reg, taken_next;
    logic [TOTAL_W-1:0] rsum_reg, rsum_next;
    logic [PROD_W-1:0]  prod_lo_reg, prod_lo_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic               out_valid_reg, out_valid_next;
    bms_result_t        out_data_reg, out_data_next;

    logic [IDXW-1:0]    rd_addr;
    logic [IDXW-1:0]    wr_addr;
    entry_t             wr_entry;
    entry_t             rd_entry;
    logic [FRAC_W-1:0]  frac_sel;
    logic [PROD_W-1:0]  prod_hi;
    logic [LIMIT_W-1:0] rsum_scaled;
    logic               bulk_ok;
    logic               out_free;

    // Configuration registers.
    always_comb
    begin
        ref_frac_next = ref_frac_reg;
        ref_thr_next  = ref_thr_reg;
        coa_frac_next = coa_frac_reg;
        coa_thr_next  = coa_thr_reg;
        if (cfg_write_enable)
        begin
            case (cfg_index)
                REG_REFINE_FRACTION:  ref_frac_next = cfg_data[FRAC_W-1:0];
                REG_REFINE_THRESHOLD: ref_thr_next  = cfg_data[VALUE_W-1:0];
                REG_COARSE_FRACTION:  coa_frac_next = cfg_data[FRAC_W-1:0];
                REG_COARSE_THRESHOLD: coa_thr_next  = cfg_data[VALUE_W-1:0];
                default:              ref_frac_next = ref_frac_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_frac_reg <= FRAC_RESET;
            ref_thr_reg  <= '0;
            coa_frac_reg <= FRAC_RESET;
            coa_thr_reg  <= '0;
        end
        else
        begin
            ref_frac_reg <= ref_frac_next;
            ref_thr_reg  <= ref_thr_next;
            coa_frac_reg <= coa_frac_next;
            coa_thr_reg  <= coa_thr_next;
        end
    end

    // Sorted order memory: entries ascend by value, ties by load position.
    always_comb
    begin
        case (cmd.addr_mode)
            ADDR_PTR:    rd_addr = IDXW'(ptr_reg);
            ADDR_PTR_M1: rd_addr = IDXW'(ptr_reg - CW'(1));
            ADDR_PTR_M2: rd_addr = IDXW'(ptr_reg - CW'(2));
            default:     rd_addr = IDXW'(ptr_reg);
        endcase
    end

    assign wr_addr        = IDXW'(ptr_reg);
    assign wr_entry.value = cmd.wr_new ? v_reg : rd_entry.value;
    assign wr_entry.idx   = cmd.wr_new ? IDXW'(count_reg) : rd_entry.idx;

    bms_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_order_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_new | cmd.wr_shift),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    // Bulk limit: fraction times total, built from two half products.
    assign frac_sel    = cmd.coarse ? coa_frac_reg : ref_frac_reg;
    assign prod_hi     = PROD_W'(frac_sel) * PROD_W'(total_reg[TOTAL_W-1:HALF_W]);
    assign rsum_scaled = {1'b0, rsum_reg, 16'h0000};
    assign bulk_ok     = (rsum_scaled <= limit_reg);
    assign out_free    = !out_valid_reg || !result_stall;

    // Run state, walk pointer and scan accumulators.
    always_comb
    begin
        v_next       = v_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        ovf_next     = ovf_reg;
        ptr_next     = ptr_reg;
        taken_next   = taken_reg;
        rsum_next    = rsum_reg;
        prod_lo_next = prod_lo_reg;
        limit_next   = limit_reg;

        if (cmd.accept)
        begin
            v_next    = item.error_value;
            last_next = item.last;
        end
        if (cmd.ovf_set)
        begin
            ovf_next = 1'b1;
        end

        if (cmd.ptr_to_count)
        begin
            ptr_next = count_reg;
        end
        else if (cmd.ptr_clr)
        begin
            ptr_next = '0;
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = ptr_reg - CW'(1);
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + CW'(1);
        end

        if (cmd.commit)
        begin
            count_next = count_reg + CW'(1);
            total_next = total_reg + TOTAL_W'(v_reg);
        end

        if (cmd.mul_lo)
        begin
            prod_lo_next = PROD_W'(frac_sel) * PROD_W'(total_reg[HALF_W-1:0]);
        end
        if (cmd.mul_hi)
        begin
            limit_next = LIMIT_W'(prod_lo_reg) + (LIMIT_W'(prod_hi) << HALF_W);
        end

        if (cmd.scan_init)
        begin
            rsum_next  = '0;
            taken_next = '0;
        end
        else if (cmd.take)
        begin
            rsum_next  = rsum_reg + TOTAL_W'(rd_entry.value);
            taken_next = taken_reg + TAKEN_W'(1);
        end
        else if (cmd.emit_seq)
        begin
            taken_next = taken_reg + TAKEN_W'(1);
        end

        if (cmd.clear_run)
        begin
            count_next = '0;
            total_next = '0;
            ovf_next   = 1'b0;
            rsum_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= 1'b0;
            count_reg <= '0;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
            ptr_reg   <= '0;
            taken_reg <= '0;
            rsum_reg  <= '0;
        end
        else
        begin
            last_reg  <= last_next;
            count_reg <= count_next;
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
            ptr_reg   <= ptr_next;
            taken_reg <= taken_next;
            rsum_reg  <= rsum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg       <= v_next;
        prod_lo_reg <= prod_lo_next;
        limit_reg   <= limit_next;
    end

    // Output register: loaded only when the slot is free.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.take)
        begin
            out_valid_next              = 1'b1;
            out_data_next.element_index = ELEM_IDX_W'(rd_entry.idx);
            out_data_next.list_kind     = cmd.coarse ? KIND_COARSE : KIND_REFINE;
            out_data_next.overflow      = 1'b0;
            out_data_next.end_of_run    = 1'b0;
        end
        else if (cmd.emit_seq)
        begin
            out_valid_next              = 1'b1;
            out_data_next.element_index = ELEM_IDX_W'(ptr_reg);
            out_data_next.list_kind     = cmd.coarse ? KIND_COARSE : KIND_REFINE;
            out_data_next.overflow      = 1'b0;
            out_data_next.end_of_run    = 1'b0;
        end
        else if (cmd.emit_close)
        begin
            out_valid_next              = 1'b1;
            out_data_next.element_index = '0;
            out_data_next.list_kind     = KIND_CLOSE;
            out_data_next.overflow      = ovf_reg;
            out_data_next.end_of_run    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // Status to the controller.
    assign stat.room         = (count_reg < CW'(MAX_ELEMENTS));
    assign stat.count_zero   = (count_reg == '0);
    assign stat.item_last    = last_reg;
    assign stat.ptr_zero     = (ptr_reg == '0);
    assign stat.ptr_one      = (ptr_reg == CW'(1));
    assign stat.ptr_at_count = (ptr_reg == count_reg);
    assign stat.taken_full   = (taken_reg == TAKEN_W'(LIST_CAP));
    assign stat.rd_gt_v      = (rd_entry.value > v_reg);
    assign stat.ref_all      = (ref_frac_reg == FRAC_ONE);
    assign stat.coa_all      = (coa_frac_reg == FRAC_ONE);
    assign stat.ref_ok       = (rd_entry.value > ref_thr_reg) && bulk_ok;
    assign stat.coa_ok       = (rd_entry.value < coa_thr_reg) && bulk_ok;
    assign stat.out_free     = out_free;

endmodule

// ===== design/bulk_error_marking_selector.sv =====
// Top level of the bulk error marking selector: controller plus datapath.
// Timing: after acceptance an item keeps the input stalled while each stored entry larger than it
// moves up one place; the order memory moves one entry a cycle. A last item then runs per list a
// limit setup in two multiply steps and a read and a check per examined entry until the order, the
// list cap or the rule runs out, or emits each element in order when a fraction is one, then the
// closing item, each emission waiting for a free output slot. Throughput: one item at a time.
// Reset: rst_n clears configuration to defaults and all run state; the order memory is not reset.
module bulk_error_marking_selector
    import bms_pkg::*;
#(
    parameter int MAX_ELEMENTS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  bms_item_t              item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output bms_result_t            result,
    input  logic                   cfg_write_enable,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    bms_cmd_t  cmd;
    bms_stat_t stat;

    // Sequencer.
    bms_controller u_controller (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Storage and arithmetic.
    bms_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .item             (item),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .stat             (stat),
        .result_stall     (result_stall),
        .result_valid     (result_valid),
        .result           (result)
    );

endmodule

// ===== design/bms_checker.sv =====
// Port-level checks on the selector's result transactions, bound to the top level.
module bms_checker
    import bms_pkg::*;
#(
    parameter int MAX_ELEMENTS = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input bms_result_t result
);

    // A stalled result transaction stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

    // The closing item carries the end mark and no element.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.list_kind == KIND_CLOSE |->
            result.end_of_run && result.element_index == '0)
    else $error("closing item malformed");

    // Element items never carry closing flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.list_kind != KIND_CLOSE |->
            !result.end_of_run && !result.overflow)
    else $error("element item carries closing flags");

    // Element positions stay inside the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.list_kind != KIND_CLOSE |->
            int'(result.element_index) < MAX_ELEMENTS)
    else $error("element index beyond capacity");

endmodule

bind bulk_error_marking_selector bms_checker #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
) u_bms_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ===== test/tb_top.sv =====
// Testbench for the bulk error marking selector: directed table, random sets, scoreboard.
module tb_top
    import bms_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ELEMENTS    = 16;
    localparam int SETTLE_CYCLES   = 40;
    localparam int IDLE_LIMIT      = 2000;
    localparam int RANDOM_ITEMS    = 130;
    localparam int PRESSURE_AT     = 60;
    localparam int PRESSURE_CYCLES = 240;
    localparam int NUM_DIRECTED    = 34;

    // Value styles for a random set.
    localparam int STYLE_WIDE    = 0;
    localparam int STYLE_TIES    = 1;
    localparam int STYLE_EXTREME = 2;

    typedef bms_result_t [0:3] mark_set_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } row_kind_t;

    // One row of the directed table: an input transaction or a register write.
    // Where n_typed is nonzero, the listed marks replace the predicted ones.
    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  data;
        logic                   last;
        logic [2:0]             n_typed;
        mark_set_t              typed;
    } stim_row_t;

    localparam bms_result_t NO_MARK     = '0;
    localparam mark_set_t   NO_MARKS    = '0;
    localparam bms_result_t CLOSE_CLEAN = '{4'd0, KIND_CLOSE, 1'b0, 1'b1};
    localparam bms_result_t REFINE_0    = '{4'd0, KIND_REFINE, 1'b0, 1'b0};
    localparam bms_result_t REFINE_1    = '{4'd1, KIND_REFINE, 1'b0, 1'b0};
    localparam bms_result_t REFINE_2    = '{4'd2, KIND_REFINE, 1'b0, 1'b0};
    localparam bms_result_t COARSE_0    = '{4'd0, KIND_COARSE, 1'b0, 1'b0};
    localparam bms_result_t COARSE_1    = '{4'd1, KIND_COARSE, 1'b0, 1'b0};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    bms_item_t              item = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    bms_result_t            result;
    logic                   cfg_write_enable = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_REFINE_FRACTION;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Predictor state: configuration copy and the current set.
    logic [FRAC_W-1:0]  refine_frac = FRAC_RESET;
    logic [VALUE_W-1:0] refine_thr = '0;
    logic [FRAC_W-1:0]  coarse_frac = FRAC_RESET;
    logic [VALUE_W-1:0] coarse_thr = '0;
    logic [VALUE_W-1:0] stored_value [MAX_ELEMENTS];
    logic [3:0]         sort_order [MAX_ELEMENTS];
    int                 stored_count = 0;
    logic [TOTAL_W-1:0] error_total = '0;
    logic               dropped_seen = 1'b0;

    bms_result_t new_marks [$];
    bms_result_t marks_due [$];
    int          marks_checked = 0;
    int          mismatches = 0;
    bit          full_rate = 1'b0;

    stim_row_t directed_rows [NUM_DIRECTED] = '{
        // Defaults after reset: a lone zero marks nothing, a lone maximum is refined.
        '{ROW_ITEM, '0, 32'h0000_0000, 1'b1, 3'd1, '{CLOSE_CLEAN, NO_MARK, NO_MARK, NO_MARK}},
        '{ROW_ITEM, '0, 32'hFFFF_FFFF, 1'b1, 3'd2, '{REFINE_0, CLOSE_CLEAN, NO_MARK, NO_MARK}},
        // Equal values: the later load index sits higher in the order.
        '{ROW_ITEM, '0, 32'd7, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'd7, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'd7, 1'b1, 3'd0, NO_MARKS},
        // Refine fraction of one: everything refined in load order.
        '{ROW_REG, REG_REFINE_FRACTION, 32'h0001_0000, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'd5, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'd0, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'hFFFF_FFFF, 1'b1, 3'd4, '{REFINE_0, REFINE_1, REFINE_2, CLOSE_CLEAN}},
        // Coarse fraction of one with refine below one: everything coarsened.
        '{ROW_REG, REG_REFINE_FRACTION, 32'h0000_0000, 1'b0, 3'd0, NO_MARKS},
        '{ROW_REG, REG_COARSE_FRACTION, 32'h0001_0000, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'd9, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'd9, 1'b1, 3'd3, '{COARSE_0, COARSE_1, CLOSE_CLEAN, NO_MARK}},
        // Fractions above one (the coarse write also carries bits beyond the width).
        '{ROW_REG, REG_REFINE_FRACTION, 32'h0001_FFFF, 1'b0, 3'd0, NO_MARKS},
        '{ROW_REG, REG_COARSE_FRACTION, 32'hFFFF_FFFF, 1'b0, 3'd0, NO_MARKS},
        '{ROW_REG, REG_REFINE_THRESHOLD, 32'h0000_0000, 1'b0, 3'd0, NO_MARKS},
        '{ROW_REG, REG_COARSE_THRESHOLD, 32'hFFFF_FFFF, 1'b0, 3'd0, NO_MARKS},
        // A full set plus one dropped input that carries the last flag.
        '{ROW_ITEM, '0, 32'h0000_0000, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'hFFFF_FFFF, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'h0000_0001, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'hFFFF_FFFE, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'h8000_0000, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'h7FFF_FFFF, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'h0000_0005, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'h0000_0005, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'h0000_0005, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'h0000_0000, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'hFFFF_FFFF, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'hAAAA_AAAA, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'h5555_5555, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'h1234_5678, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'h0000_0005, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'h0000_0000, 1'b0, 3'd0, NO_MARKS},
        '{ROW_ITEM, '0, 32'hFFFF_FFFF, 1'b1, 3'd0, NO_MARKS}
    };

    bulk_error_marking_selector #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .cfg_write_enable(cfg_write_enable),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic bms_result_t make_mark(input logic [3:0] idx, input list_kind_t kind,
                                              input logic ovf, input logic eor);
        bms_result_t m;
        m.element_index = idx;
        m.list_kind     = kind;
        m.overflow      = ovf;
        m.end_of_run    = eor;
        return m;
    endfunction

    // Predict the marks caused by one accepted transaction into new_marks.
    task automatic predict_marks(input bms_item_t word);
        logic [63:0]        bound;
        logic [63:0]        acc;
        logic [3:0]         e;
        logic [VALUE_W-1:0] ev;
        int                 pos;
        int                 k;
        int                 taken;
        new_marks.delete();

        // Insert into the ascending order; an equal value goes behind earlier ones.
        if (stored_count < MAX_ELEMENTS)
        begin
            pos = 0;
            while (pos < stored_count && stored_value[sort_order[pos]] <= word.error_value)
                pos++;
            for (k = stored_count; k > pos; k--)
                sort_order[k] = sort_order[k - 1];
            sort_order[pos] = 4'(stored_count);
            stored_value[stored_count] = word.error_value;
            stored_count++;
            error_total = error_total + TOTAL_W'(word.error_value);
        end
        else
        begin
            dropped_seen = 1'b1;
        end
        if (!word.last)
            return;

        if (refine_frac == FRAC_ONE)
        begin
            for (k = 0; k < stored_count; k++)
                new_marks = {new_marks, make_mark(4'(k), KIND_REFINE, 1'b0, 1'b0)};
        end
        else if (coarse_frac == FRAC_ONE)
        begin
            for (k = 0; k < stored_count; k++)
                new_marks = {new_marks, make_mark(4'(k), KIND_COARSE, 1'b0, 1'b0)};
        end
        else
        begin
            // Refine list: largest first, sum checked before the element is added.
            bound = 64'(refine_frac) * 64'(error_total);
            acc   = '0;
            taken = 0;
            for (k = stored_count; k > 0 && taken < LIST_CAP; k--)
            begin
                e  = sort_order[k - 1];
                ev = stored_value[e];
                if (ev <= refine_thr || (acc << 16) > bound)
                    break;
                new_marks = {new_marks, make_mark(e, KIND_REFINE, 1'b0, 1'b0)};
                taken++;
                acc = 64'(TOTAL_W'(acc + 64'(ev)));
            end
            // Coarse list: smallest first under the mirrored rule.
            bound = 64'(coarse_frac) * 64'(error_total);
            acc   = '0;
            taken = 0;
            for (k = 0; k < stored_count && taken < LIST_CAP; k++)
            begin
                e  = sort_order[k];
                ev = stored_value[e];
                if (ev >= coarse_thr || (acc << 16) > bound)
                    break;
                new_marks = {new_marks, make_mark(e, KIND_COARSE, 1'b0, 1'b0)};
                taken++;
                acc = 64'(TOTAL_W'(acc + 64'(ev)));
            end
        end
        new_marks = {new_marks, make_mark(4'd0, KIND_CLOSE, dropped_seen, 1'b1)};
        stored_count = 0;
        error_total  = '0;
        dropped_seen = 1'b0;
    endtask

    // Offer one transaction, wait for it to be taken, then queue its expected marks.
    task automatic send_item(input bms_item_t word, input int n_typed, input mark_set_t typed);
        int gap;
        int j;
        gap = full_rate ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= word;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_marks(word);
        if (n_typed == 0)
        begin
            marks_due = {marks_due, new_marks};
        end
        else
        begin
            for (j = 0; j < n_typed; j++)
                marks_due = {marks_due, typed[j]};
        end
    endtask

    // Register writes happen only once the block has drained and settled.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        item_valid <= 1'b0;
        while (marks_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= data;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        case (idx)
            REG_REFINE_FRACTION:  refine_frac = data[FRAC_W-1:0];
            REG_REFINE_THRESHOLD: refine_thr  = data;
            REG_COARSE_FRACTION:  coarse_frac = data[FRAC_W-1:0];
            REG_COARSE_THRESHOLD: coarse_thr  = data;
            default: ;
        endcase
    endtask

    // Compare one received mark with the oldest expectation.
    task automatic check_mark(input bms_result_t got);
        bms_result_t want;
        marks_checked++;
        if (marks_due.size() == 0)
        begin
            $error("unexpected result: element_index %0d, list_kind %0d",
                   got.element_index, got.list_kind);
            mismatches++;
            return;
        end
        want = marks_due.pop_front();
        if (got.element_index !== want.element_index)
        begin
            $error("element_index: expected %0d, got %0d", want.element_index, got.element_index);
            mismatches++;
        end
        if (got.list_kind !== want.list_kind)
        begin
            $error("list_kind: expected %0d, got %0d", want.list_kind, got.list_kind);
            mismatches++;
        end
        if (got.overflow !== want.overflow)
        begin
            $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
            mismatches++;
        end
        if (got.end_of_run !== want.end_of_run)
        begin
            $error("end_of_run: expected %0d, got %0d", want.end_of_run, got.end_of_run);
            mismatches++;
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] draw_fraction();
        logic [CFG_DATA_W-1:0] f;
        case ($urandom_range(0, 7))
            0:       f = '0;
            1:       f = CFG_DATA_W'(FRAC_ONE);
            2:       f = 32'h0001_FFFF;
            default: f = $urandom_range(0, 65535);
        endcase
        // Bits above the register width must have no effect.
        if ($urandom_range(0, 1) == 1)
            f = f | ($urandom() & 32'hFFFE_0000);
        return f;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] draw_threshold();
        logic [CFG_DATA_W-1:0] t;
        case ($urandom_range(0, 4))
            0:       t = '0;
            1:       t = 32'hFFFF_FFFF;
            2:       t = $urandom_range(0, 16);
            default: t = $urandom();
        endcase
        return t;
    endfunction

    function automatic logic [VALUE_W-1:0] draw_value(input int style);
        logic [VALUE_W-1:0] v;
        if (style == STYLE_TIES)
            v = $urandom_range(0, 15);
        else if (style == STYLE_EXTREME)
        begin
            case ($urandom_range(0, 2))
                0:       v = '0;
                1:       v = 32'hFFFF_FFFF;
                default: v = $urandom();
            endcase
        end
        else
            v = $urandom();
        return v;
    endfunction

    // Result side: random stalls per transaction, and one long hold-off under load.
    initial
    begin : result_side
        int stall_left;
        bit pressed;
        stall_left = 0;
        pressed    = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                check_mark(result);
                stall_left = full_rate ? 0 : $urandom_range(0, 3);
                if (!pressed && marks_checked >= PRESSURE_AT && item_valid)
                begin
                    stall_left = PRESSURE_CYCLES;
                    pressed    = 1'b1;
                end
                result_stall <= (stall_left != 0);
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                result_stall <= (stall_left != 0);
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // Stimulus: reset, directed table, then random phases of configuration and sets.
    initial
    begin : stimulus
        bms_item_t word;
        int        random_sent;
        int        set_len;
        int        style;
        int        k;
        random_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_REG)
                write_reg(directed_rows[r].reg_index, directed_rows[r].data);
            else
            begin
                word.error_value = directed_rows[r].data;
                word.last        = directed_rows[r].last;
                send_item(word, directed_rows[r].n_typed, directed_rows[r].typed);
            end
        end

        while (random_sent < RANDOM_ITEMS)
        begin
            full_rate = ($urandom_range(0, 4) == 0);
            write_reg(REG_REFINE_FRACTION, draw_fraction());
            write_reg(REG_REFINE_THRESHOLD, draw_threshold());
            write_reg(REG_COARSE_FRACTION, draw_fraction());
            write_reg(REG_COARSE_THRESHOLD, draw_threshold());
            repeat ($urandom_range(2, 4))
            begin
                // Mostly small sets, some full ones, a few that overrun capacity.
                case ($urandom_range(0, 9))
                    0:       set_len = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 3);
                    1, 2:    set_len = $urandom_range(9, MAX_ELEMENTS);
                    default: set_len = $urandom_range(1, 8);
                endcase
                style = $urandom_range(STYLE_WIDE, STYLE_EXTREME);
                for (k = 0; k < set_len; k++)
                begin
                    word.error_value = draw_value(style);
                    word.last        = (k == set_len - 1);
                    send_item(word, 0, NO_MARKS);
                    random_sent++;
                end
            end
        end

        // Drain and let the block settle before the verdict.
        item_valid <= 1'b0;
        while (marks_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
